/* rtl/core/asc_pkg.sv */
// asc_pkg: shared types, codes, constants and helper functions for the
// alarm snooze controller; no dependencies
package asc_pkg;

  typedef enum logic [2:0] {
    MODE_OFF    = 3'd0,
    MODE_ON     = 3'd1,
    MODE_RING   = 3'd2,
    MODE_SNOOZE = 3'd3,
    MODE_ACK    = 3'd4
  } mode_t;

  localparam logic [2:0] FUNC_TIME  = 3'd0;
  localparam logic [2:0] FUNC_ALARM = 3'd1;
  localparam logic [2:0] FUNC_NIGHT = 3'd2;
  localparam logic [2:0] FUNC_TOUCH = 3'd3;
  localparam logic [2:0] FUNC_ARM   = 3'd4;

  localparam logic [1:0] REG_ALARM_HOUR   = 2'd0;
  localparam logic [1:0] REG_ALARM_MINUTE = 2'd1;
  localparam logic [1:0] REG_SNOOZE_STEP  = 2'd2;

  localparam logic [5:0] RST_ALARM_HOUR   = 6'h06;
  localparam logic [6:0] RST_ALARM_MINUTE = 7'h30;
  localparam logic [5:0] RST_SNOOZE_STEP  = 6'd8;

  localparam logic [6:0] FULL_LIGHT  = 7'd100;
  localparam logic [6:0] NIGHT_LIGHT = 7'd2;
  localparam logic [7:0] MIN_PER_HR  = 8'd60;

  typedef struct packed {
    logic [5:0] alarm_hour;
    logic [6:0] alarm_minute;
    logic [5:0] snooze_step;
  } cfg_t;

  typedef struct packed {
    logic [2:0] func;
    logic [5:0] hour;
    logic [6:0] minute;
    logic [6:0] second;
  } item_t;

  // high digit * 10 + low digit, invalid digits taken as is
  function automatic logic [6:0] bcd_value(input logic [6:0] b);
    logic [6:0] r;
    r = {1'b0, b[6:4], 3'b000} + {3'b000, b[6:4], 1'b0} + {3'b000, b[3:0]};
    return r;
  endfunction

  // valid for v below 180
  function automatic logic [5:0] mod60(input logic [7:0] v);
    logic [7:0] r;
    if (v >= 8'(2 * MIN_PER_HR)) begin
      r = v - 8'(2 * MIN_PER_HR);
    end else if (v >= MIN_PER_HR) begin
      r = v - MIN_PER_HR;
    end else begin
      r = v;
    end
    return r[5:0];
  endfunction

endpackage

/* rtl/core/asc_regs.sv */
// asc_regs: apb configuration registers for alarm time and snooze step
// depends on asc_pkg
module asc_regs
  import asc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  cfg_t       regs;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel & penable & pwrite & pready;
  assign cfg     = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.alarm_hour   <= RST_ALARM_HOUR;
      regs.alarm_minute <= RST_ALARM_MINUTE;
      regs.snooze_step  <= RST_SNOOZE_STEP;
    end else if (wr_en) begin
      case (reg_idx)
        REG_ALARM_HOUR:   regs.alarm_hour   <= pwdata[5:0];
        REG_ALARM_MINUTE: regs.alarm_minute <= pwdata[6:0];
        REG_SNOOZE_STEP:  regs.snooze_step  <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_ALARM_HOUR:   prdata = {26'd0, regs.alarm_hour};
      REG_ALARM_MINUTE: prdata = {25'd0, regs.alarm_minute};
      REG_SNOOZE_STEP:  prdata = {26'd0, regs.snooze_step};
      default:          prdata = 32'd0;
    endcase
  end

endmodule

/* rtl/core/asc_in_stage.sv */
// asc_in_stage: input register holding one transaction for the core
// depends on asc_pkg
module asc_in_stage
  import asc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] func,
  input  logic [5:0] hour_bcd,
  input  logic [6:0] minute_bcd,
  input  logic [6:0] second_bcd,
  input  logic       core_ready,
  output logic       item_valid,
  output item_t      item
);

  logic  held;
  item_t data;

  assign in_stall   = held & ~core_ready;
  assign item_valid = held;
  assign item       = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (!in_stall) begin
      held <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      data.func   <= func;
      data.hour   <= hour_bcd;
      data.minute <= minute_bcd;
      data.second <= second_bcd;
    end
  end

endmodule

/* rtl/core/asc_core.sv */
// asc_core: alarm state machine, snooze offset, night flag and result register
// depends on asc_pkg
module asc_core
  import asc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       item_valid,
  input  item_t      item,
  output logic       core_ready,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] alarm_mode,
  output logic       bell_lit,
  output logic [6:0] backlight_level,
  output logic       night_mode,
  output logic       start_sound
);

  mode_t      mode, mode_next;
  logic [5:0] snooze_offset, snooze_offset_next;
  logic       night_flag, night_flag_next;
  logic [6:0] backlight, backlight_next;
  logic       second_odd, second_odd_next;
  logic       start_next, bell_next;

  mode_t      res_mode;
  logic       res_bell, res_night, res_start;
  logic [6:0] res_light;

  logic       take;
  logic [5:0] step_m;
  logic [5:0] target;
  logic       hour_hit;

  assign core_ready = ~out_valid | ~out_stall;
  assign take       = item_valid & core_ready;

  assign step_m   = (cfg.snooze_step >= 6'(MIN_PER_HR)) ?
                    cfg.snooze_step - 6'(MIN_PER_HR) : cfg.snooze_step;
  assign target   = mod60({1'b0, bcd_value(cfg.alarm_minute)} + {2'b00, snooze_offset});
  assign hour_hit = item.hour == cfg.alarm_hour;

  // next state
  always_comb begin
    mode_next          = mode;
    snooze_offset_next = snooze_offset;
    night_flag_next    = night_flag;
    backlight_next     = backlight;
    second_odd_next    = second_odd;
    start_next         = 1'b0;
    case (item.func)
      FUNC_TIME: begin
        second_odd_next = item.second[0];
        case (mode)
          MODE_ON: begin
            if (hour_hit && item.minute == cfg.alarm_minute) begin
              mode_next          = MODE_RING;
              snooze_offset_next = step_m;
              backlight_next     = FULL_LIGHT;
              start_next         = 1'b1;
            end
          end
          MODE_SNOOZE: begin
            if (hour_hit && bcd_value(item.minute) == {1'b0, target}) begin
              mode_next          = MODE_RING;
              snooze_offset_next = mod60({2'b00, snooze_offset} + {2'b00, step_m});
              backlight_next     = FULL_LIGHT;
              start_next         = 1'b1;
            end
          end
          MODE_ACK: begin
            if (item.minute != cfg.alarm_minute) begin
              mode_next = MODE_ON;
            end
          end
          default: ;
        endcase
      end
      FUNC_ALARM, FUNC_NIGHT, FUNC_TOUCH: begin
        if (mode == MODE_RING) begin
          mode_next = MODE_SNOOZE;
          if (night_flag) begin
            backlight_next = NIGHT_LIGHT;
          end
        end else if (item.func == FUNC_ALARM) begin
          case (mode)
            MODE_ON:     mode_next = MODE_OFF;
            MODE_OFF:    mode_next = MODE_ON;
            MODE_SNOOZE: mode_next = MODE_ACK;
            default: ;
          endcase
        end else if (item.func == FUNC_NIGHT) begin
          night_flag_next = ~night_flag;
          backlight_next  = night_flag ? FULL_LIGHT : NIGHT_LIGHT;
        end
      end
      FUNC_ARM: mode_next = MODE_ON;
      default: ;
    endcase
  end

  // outputs
  always_comb begin
    case (mode_next)
      MODE_OFF:  bell_next = 1'b0;
      MODE_RING: bell_next = second_odd_next;
      default:   bell_next = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_OFF;
      snooze_offset <= 6'd0;
      night_flag    <= 1'b0;
      backlight     <= FULL_LIGHT;
      second_odd    <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (take) begin
        mode          <= mode_next;
        snooze_offset <= snooze_offset_next;
        night_flag    <= night_flag_next;
        backlight     <= backlight_next;
        second_odd    <= second_odd_next;
        out_valid     <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_mode  <= mode_next;
      res_bell  <= bell_next;
      res_light <= backlight_next;
      res_night <= night_flag_next;
      res_start <= start_next;
    end
  end

  assign alarm_mode      = res_mode;
  assign bell_lit        = res_bell;
  assign backlight_level = res_light;
  assign night_mode      = res_night;
  assign start_sound     = res_start;

  a_offset_range: assert property (@(posedge clk) disable iff (rst)
    snooze_offset < 6'(MIN_PER_HR))
    else $error("snooze offset out of range");

  a_start_rings: assert property (@(posedge clk) disable iff (rst)
    out_valid && start_sound |-> alarm_mode == MODE_RING)
    else $error("start pulse outside ringing");

  a_day_light: assert property (@(posedge clk) disable iff (rst)
    !night_flag |-> backlight == FULL_LIGHT)
    else $error("dimmed backlight without night flag");

  a_light_levels: assert property (@(posedge clk) disable iff (rst)
    backlight == FULL_LIGHT || backlight == NIGHT_LIGHT)
    else $error("unexpected backlight level");

  a_ring_offset: assert property (@(posedge clk) disable iff (rst)
    take && start_next |=> mode == MODE_RING)
    else $error("ring entry lost");

endmodule

/* rtl/core/alarm_snooze_controller.sv */
// alarm_snooze_controller: top level of the alarm snooze controller
// depends on asc_pkg, asc_regs, asc_in_stage, asc_core
//
// usage: each input transaction (in_valid/in_stall) carries func and the
// current time in bcd; func 0 is a time sample, 1 alarm button, 2 night
// button, 3 other touch, 4 arm alarm. every input transaction gives exactly
// one result transaction (out_valid/out_stall) with the state after it:
// alarm_mode, bell_lit, backlight_level, night_mode and start_sound.
// out_valid rises once the input transaction has passed the input register
// and been taken into the result register; one transaction per cycle is
// taken while out_stall does not hold the result, set by the state update
// between the input register and the result register.
// alarm hour, alarm minute and snooze step sit on the apb port at byte
// addresses 0, 4 and 8; write them only while the block is idle.
// reset clears the mode to off, the snooze offset and night flag to zero,
// the backlight to 100 and loads the register defaults (06:30, step 8).
// while out_stall is high the result holds; at most one more transaction is
// taken into the input register, after which in_stall rises.
module alarm_snooze_controller
  import asc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  func,
  input  logic [5:0]  hour_bcd,
  input  logic [6:0]  minute_bcd,
  input  logic [6:0]  second_bcd,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  alarm_mode,
  output logic        bell_lit,
  output logic [6:0]  backlight_level,
  output logic        night_mode,
  output logic        start_sound
);

  cfg_t  cfg;
  item_t item;
  logic  item_valid;
  logic  core_ready;

  asc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  asc_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .func       (func),
    .hour_bcd   (hour_bcd),
    .minute_bcd (minute_bcd),
    .second_bcd (second_bcd),
    .core_ready (core_ready),
    .item_valid (item_valid),
    .item       (item)
  );

  asc_core u_core (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .item_valid      (item_valid),
    .item            (item),
    .core_ready      (core_ready),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .alarm_mode      (alarm_mode),
    .bell_lit        (bell_lit),
    .backlight_level (backlight_level),
    .night_mode      (night_mode),
    .start_sound     (start_sound)
  );

endmodule
